FILE: src/truncated_cone_box_centre_test_macros.svh
// Assertion macros for the truncated cone centre test.
// Included by the top level; expects clk and arst_n in the including scope.
`ifndef TRUNCATED_CONE_BOX_CENTRE_TEST_MACROS_SVH
`define TRUNCATED_CONE_BOX_CENTRE_TEST_MACROS_SVH

// Same-cycle implication, disabled during reset
`define TCBCT_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled during reset
`define TCBCT_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: src/tcbct_pkg.sv
// Shared widths, types, register codes and arithmetic helpers for the cone test.
// No dependencies; used by the channel interfaces and the top level.
package tcbct_pkg;

	localparam int COORD_W   = 32;
	localparam int FRAC_BITS = 16;

	localparam int N_AX     = 3;
	localparam int N_SQ     = 4;
	localparam int RAD_SLOT = 3;
	localparam int STAGES   = 12;
	localparam int CFG_IDX_W = 4;

	// Widths of the axial stage
	localparam int V_W   = COORD_W + 1;
	localparam int W_W   = COORD_W + 2;
	localparam int VV_W  = 2 * V_W;
	localparam int WV_W  = W_W + V_W;
	localparam int D_W   = VV_W + 2;
	localparam int DOT_W = WV_W + 2;
	localparam int CMP_W = DOT_W + 1;

	// Widths of the split long-by-short products
	localparam int LIMB_W  = COORD_W + 2;
	localparam int LONG_W  = 2 * COORD_W + 3;
	localparam int HI_W    = LONG_W - LIMB_W;
	localparam int SHORT_W = W_W;
	localparam int PLO_W   = LIMB_W + 1 + SHORT_W;
	localparam int PHI_W   = HI_W + 1 + SHORT_W;
	localparam int PW      = 3 * LIMB_W;
	localparam int PP_W    = 2 * LIMB_W;
	localparam int SQ_W    = 2 * PW;

	typedef logic signed [COORD_W-1:0] coord_t;

	localparam coord_t RADIUS_RESET = COORD_W'(-(longint'(1) << FRAC_BITS));

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_START_X = 4'd0,
		REG_START_Y = 4'd1,
		REG_START_Z = 4'd2,
		REG_START_R = 4'd3,
		REG_END_X   = 4'd4,
		REG_END_Y   = 4'd5,
		REG_END_Z   = 4'd6,
		REG_END_R   = 4'd7
	} cfg_reg_t;

	typedef logic signed [V_W-1:0]     vec_t;
	typedef logic signed [W_W-1:0]     wvec_t;
	typedef logic signed [VV_W-1:0]    vv_t;
	typedef logic signed [WV_W-1:0]    wv_t;
	typedef logic signed [D_W-1:0]     dist_t;
	typedef logic signed [DOT_W-1:0]   dot_t;
	typedef logic [LONG_W-1:0]         long_t;
	typedef logic signed [SHORT_W-1:0] short_t;
	typedef logic signed [PW-1:0]      prod_t;
	typedef logic [PW-1:0]             mag_t;
	typedef logic [SQ_W-1:0]           sq_t;

	typedef struct packed {
		logic signed [PHI_W-1:0] hi;
		logic signed [PLO_W-1:0] lo;
	} pp_t;

	typedef struct packed {
		logic [PP_W-1:0] p00;
		logic [PP_W-1:0] p11;
		logic [PP_W-1:0] p22;
		logic [PP_W-1:0] p01;
		logic [PP_W-1:0] p02;
		logic [PP_W-1:0] p12;
	} sqpp_t;

	typedef struct packed {
		sq_t             acc;
		logic [PP_W-1:0] p02;
	} fold_t;

	// Two partial products of an unsigned long operand by a signed short one
	function automatic pp_t mul_split(input long_t a, input short_t b);
		logic signed [LIMB_W:0] alo;
		logic signed [HI_W:0]   ahi;
		pp_t                    r;
		alo  = {1'b0, a[LIMB_W-1:0]};
		ahi  = {1'b0, a[LONG_W-1:LIMB_W]};
		r.lo = PLO_W'(alo) * PLO_W'(b);
		r.hi = PHI_W'(ahi) * PHI_W'(b);
		return r;
	endfunction

	// Recombine the two partial products
	function automatic prod_t mul_join(input pp_t p);
		return (PW'(p.hi) <<< LIMB_W) + PW'(p.lo);
	endfunction

	// Six limb products of a three-limb square
	function automatic sqpp_t sq_parts(input mag_t a);
		logic [LIMB_W-1:0] a0;
		logic [LIMB_W-1:0] a1;
		logic [LIMB_W-1:0] a2;
		sqpp_t             r;
		a0    = a[LIMB_W-1:0];
		a1    = a[2*LIMB_W-1:LIMB_W];
		a2    = a[3*LIMB_W-1:2*LIMB_W];
		r.p00 = PP_W'(a0) * PP_W'(a0);
		r.p11 = PP_W'(a1) * PP_W'(a1);
		r.p22 = PP_W'(a2) * PP_W'(a2);
		r.p01 = PP_W'(a0) * PP_W'(a1);
		r.p02 = PP_W'(a0) * PP_W'(a2);
		r.p12 = PP_W'(a1) * PP_W'(a2);
		return r;
	endfunction

	// Diagonal terms and the non-overlapping doubled cross terms
	function automatic fold_t sq_fold(input sqpp_t p);
		fold_t f;
		f.acc = {p.p22, p.p11, p.p00} + (SQ_W'({p.p12, p.p01}) << (LIMB_W + 1));
		f.p02 = p.p02;
		return f;
	endfunction

	// Add the last doubled cross term
	function automatic sq_t sq_finish(input fold_t f);
		return f.acc + (SQ_W'(f.p02) << (2 * LIMB_W + 1));
	endfunction

endpackage

FILE: src/tcbct_if.sv
// Valid/ready channel interfaces: box input, hit result and register writes.
// Depends on tcbct_pkg for field widths.

interface tcbct_box_if;
	logic                     valid;
	logic                     ready;
	tcbct_pkg::coord_t        box_min_x;
	tcbct_pkg::coord_t        box_min_y;
	tcbct_pkg::coord_t        box_min_z;
	tcbct_pkg::coord_t        box_max_x;
	tcbct_pkg::coord_t        box_max_y;
	tcbct_pkg::coord_t        box_max_z;

	modport source (
		output valid, box_min_x, box_min_y, box_min_z, box_max_x, box_max_y, box_max_z,
		input  ready
	);
	modport sink (
		input  valid, box_min_x, box_min_y, box_min_z, box_max_x, box_max_y, box_max_z,
		output ready
	);
endinterface

interface tcbct_hit_if;
	logic valid;
	logic ready;
	logic centre_inside;

	modport source (output valid, centre_inside, input ready);
	modport sink (input valid, centre_inside, output ready);
endinterface

interface tcbct_cfg_if;
	logic                               valid;
	logic                               ready;
	logic [tcbct_pkg::CFG_IDX_W-1:0]    index;
	tcbct_pkg::coord_t                  data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

FILE: src/truncated_cone_box_centre_test.sv
// Box centre versus truncated cone test, twelve-stage pipeline; uses tcbct_pkg, tcbct_if.
// Result valid comes from the last stage register; throughput one box per cycle while the output is not stalled.
// Depth is set by the split 35x34 multipliers and the three-limb squares with their adders.
// A stalled output lets upstream stages close bubbles; input stalls only when all are full.
// Reset clears the pipeline; axis points to 0 and both radii to -1.0.
`include "truncated_cone_box_centre_test_macros.svh"

module truncated_cone_box_centre_test (
	input  logic         clk,
	input  logic         arst_n,
	tcbct_cfg_if.sink    cfg,
	tcbct_box_if.sink    box,
	tcbct_hit_if.source  hit
);

	// Cone registers
	tcbct_pkg::coord_t p0_q [tcbct_pkg::N_AX];
	tcbct_pkg::coord_t p1_q [tcbct_pkg::N_AX];
	tcbct_pkg::coord_t r0_q;
	tcbct_pkg::coord_t r1_q;

	// Derived from the registers
	tcbct_pkg::vec_t   v [tcbct_pkg::N_AX];
	tcbct_pkg::vec_t   dr;

	tcbct_pkg::coord_t bmin [tcbct_pkg::N_AX];
	tcbct_pkg::coord_t bmax [tcbct_pkg::N_AX];
	tcbct_pkg::wvec_t  w_c  [tcbct_pkg::N_AX];

	logic [tcbct_pkg::STAGES-1:0] pipe_valid_q;
	logic [tcbct_pkg::STAGES-1:0] adv;

	tcbct_pkg::long_t  dot_l;
	tcbct_pkg::long_t  d_l;
	tcbct_pkg::long_t  d2_l;

	// Pipeline payload
	tcbct_pkg::wvec_t  w_s1  [tcbct_pkg::N_AX];
	tcbct_pkg::vv_t    vv_s2 [tcbct_pkg::N_AX];
	tcbct_pkg::wv_t    wv_s2 [tcbct_pkg::N_AX];
	tcbct_pkg::wvec_t  w_s2  [tcbct_pkg::N_AX];
	tcbct_pkg::dist_t  d_s3;
	tcbct_pkg::dot_t   dot_s3;
	tcbct_pkg::wvec_t  w_s3  [tcbct_pkg::N_AX];
	tcbct_pkg::pp_t    dv_pp_s4 [tcbct_pkg::N_AX];
	tcbct_pkg::pp_t    dw_pp_s4 [tcbct_pkg::N_AX];
	tcbct_pkg::pp_t    r0_pp_s4;
	tcbct_pkg::pp_t    dr_pp_s4;
	logic              ok_s4;
	tcbct_pkg::prod_t  dv_s5 [tcbct_pkg::N_AX];
	tcbct_pkg::prod_t  dw_s5 [tcbct_pkg::N_AX];
	tcbct_pkg::prod_t  r0p_s5;
	tcbct_pkg::prod_t  drp_s5;
	logic              ok_s5;
	tcbct_pkg::prod_t  u_s6 [tcbct_pkg::N_AX];
	tcbct_pkg::prod_t  rad_s6;
	logic              ok_s6;
	tcbct_pkg::mag_t   mag_s7 [tcbct_pkg::N_SQ];
	logic              ok_s7;
	tcbct_pkg::sqpp_t  sqpp_s8 [tcbct_pkg::N_SQ];
	logic              ok_s8;
	tcbct_pkg::fold_t  fold_s9 [tcbct_pkg::N_SQ];
	logic              ok_s9;
	tcbct_pkg::sq_t    sq_s10 [tcbct_pkg::N_SQ];
	logic              ok_s10;
	tcbct_pkg::sq_t    uu01_s11;
	tcbct_pkg::sq_t    sq2_s11;
	tcbct_pkg::sq_t    rr_s11;
	logic              ok_s11;
	logic              hit_s12;

	// Register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < tcbct_pkg::N_AX; k++) begin
				p0_q[k] <= '0;
				p1_q[k] <= '0;
			end
			r0_q <= tcbct_pkg::RADIUS_RESET;
			r1_q <= tcbct_pkg::RADIUS_RESET;
		end else if (cfg.valid && cfg.ready) begin
			unique case (cfg.index)
				tcbct_pkg::REG_START_X: p0_q[0] <= cfg.data;
				tcbct_pkg::REG_START_Y: p0_q[1] <= cfg.data;
				tcbct_pkg::REG_START_Z: p0_q[2] <= cfg.data;
				tcbct_pkg::REG_START_R: r0_q    <= cfg.data;
				tcbct_pkg::REG_END_X:   p1_q[0] <= cfg.data;
				tcbct_pkg::REG_END_Y:   p1_q[1] <= cfg.data;
				tcbct_pkg::REG_END_Z:   p1_q[2] <= cfg.data;
				tcbct_pkg::REG_END_R:   r1_q    <= cfg.data;
				default: ;
			endcase
		end
	end

	assign cfg.ready = 1'b1;

	// Axis vector and radius slope
	always_comb begin
		for (int k = 0; k < tcbct_pkg::N_AX; k++) begin
			v[k] = tcbct_pkg::V_W'(p1_q[k]) - tcbct_pkg::V_W'(p0_q[k]);
		end
		dr = tcbct_pkg::V_W'(r1_q) - tcbct_pkg::V_W'(r0_q);
	end

	// Advance a stage when it is empty or the next one advances
	always_comb begin
		adv[tcbct_pkg::STAGES-1] = !pipe_valid_q[tcbct_pkg::STAGES-1] || hit.ready;
		for (int i = tcbct_pkg::STAGES - 2; i >= 0; i--) begin
			adv[i] = !pipe_valid_q[i] || adv[i+1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pipe_valid_q <= '0;
		end else begin
			if (adv[0]) begin
				pipe_valid_q[0] <= box.valid;
			end
			for (int i = 1; i < tcbct_pkg::STAGES; i++) begin
				if (adv[i]) begin
					pipe_valid_q[i] <= pipe_valid_q[i-1];
				end
			end
		end
	end

	assign box.ready         = adv[0];
	assign hit.valid         = pipe_valid_q[tcbct_pkg::STAGES-1];
	assign hit.centre_inside = hit_s12;

	// Stage 1: doubled centre relative to the doubled start point
	always_comb begin
		bmin[0] = box.box_min_x;
		bmin[1] = box.box_min_y;
		bmin[2] = box.box_min_z;
		bmax[0] = box.box_max_x;
		bmax[1] = box.box_max_y;
		bmax[2] = box.box_max_z;
		for (int k = 0; k < tcbct_pkg::N_AX; k++) begin
			w_c[k] = tcbct_pkg::W_W'(bmin[k]) + tcbct_pkg::W_W'(bmax[k])
				- (tcbct_pkg::W_W'(p0_q[k]) <<< 1);
		end
	end

	always_ff @(posedge clk) begin
		if (adv[0]) begin
			w_s1 <= w_c;
		end
	end

	// Stage 2: per-axis products for |v|^2 and w.v
	always_ff @(posedge clk) begin
		if (adv[1]) begin
			for (int k = 0; k < tcbct_pkg::N_AX; k++) begin
				vv_s2[k] <= tcbct_pkg::VV_W'(v[k]) * tcbct_pkg::VV_W'(v[k]);
				wv_s2[k] <= tcbct_pkg::WV_W'(w_s1[k]) * tcbct_pkg::WV_W'(v[k]);
			end
			w_s2 <= w_s1;
		end
	end

	// Stage 3: sum the three axes
	always_ff @(posedge clk) begin
		if (adv[2]) begin
			d_s3   <= tcbct_pkg::D_W'(vv_s2[0]) + tcbct_pkg::D_W'(vv_s2[1])
				+ tcbct_pkg::D_W'(vv_s2[2]);
			dot_s3 <= tcbct_pkg::DOT_W'(wv_s2[0]) + tcbct_pkg::DOT_W'(wv_s2[1])
				+ tcbct_pkg::DOT_W'(wv_s2[2]);
			w_s3   <= w_s2;
		end
	end

	// Stage 4: axial range check and split partial products
	assign dot_l = dot_s3[tcbct_pkg::LONG_W-1:0];
	assign d_l   = d_s3[tcbct_pkg::LONG_W-1:0];
	assign d2_l  = {d_s3[tcbct_pkg::LONG_W-2:0], 1'b0};

	always_ff @(posedge clk) begin
		if (adv[3]) begin
			ok_s4 <= (d_s3 != '0) && !dot_s3[tcbct_pkg::DOT_W-1]
				&& (tcbct_pkg::CMP_W'(dot_s3) <= (tcbct_pkg::CMP_W'(d_s3) <<< 1));
			for (int k = 0; k < tcbct_pkg::N_AX; k++) begin
				dv_pp_s4[k] <= tcbct_pkg::mul_split(dot_l, tcbct_pkg::SHORT_W'(v[k]));
				dw_pp_s4[k] <= tcbct_pkg::mul_split(d_l, w_s3[k]);
			end
			r0_pp_s4 <= tcbct_pkg::mul_split(d2_l, tcbct_pkg::SHORT_W'(r0_q));
			dr_pp_s4 <= tcbct_pkg::mul_split(dot_l, tcbct_pkg::SHORT_W'(dr));
		end
	end

	// Stage 5: recombine partial products
	always_ff @(posedge clk) begin
		if (adv[4]) begin
			for (int k = 0; k < tcbct_pkg::N_AX; k++) begin
				dv_s5[k] <= tcbct_pkg::mul_join(dv_pp_s4[k]);
				dw_s5[k] <= tcbct_pkg::mul_join(dw_pp_s4[k]);
			end
			r0p_s5 <= tcbct_pkg::mul_join(r0_pp_s4);
			drp_s5 <= tcbct_pkg::mul_join(dr_pp_s4);
			ok_s5  <= ok_s4;
		end
	end

	// Stage 6: scaled offset from the axis and scaled radius
	always_ff @(posedge clk) begin
		if (adv[5]) begin
			for (int k = 0; k < tcbct_pkg::N_AX; k++) begin
				u_s6[k] <= dv_s5[k] - dw_s5[k];
			end
			rad_s6 <= r0p_s5 + drp_s5;
			ok_s6  <= ok_s5;
		end
	end

	// Stage 7: magnitudes; drop non-positive radius
	always_ff @(posedge clk) begin
		if (adv[6]) begin
			for (int k = 0; k < tcbct_pkg::N_AX; k++) begin
				mag_s7[k] <= u_s6[k][tcbct_pkg::PW-1] ? tcbct_pkg::mag_t'(-u_s6[k])
					: tcbct_pkg::mag_t'(u_s6[k]);
			end
			mag_s7[tcbct_pkg::RAD_SLOT] <= tcbct_pkg::mag_t'(rad_s6);
			ok_s7 <= ok_s6 && !rad_s6[tcbct_pkg::PW-1] && (rad_s6 != '0);
		end
	end

	// Stage 8: limb products of the four squares
	always_ff @(posedge clk) begin
		if (adv[7]) begin
			for (int k = 0; k < tcbct_pkg::N_SQ; k++) begin
				sqpp_s8[k] <= tcbct_pkg::sq_parts(mag_s7[k]);
			end
			ok_s8 <= ok_s7;
		end
	end

	// Stage 9: fold diagonal and adjacent cross terms
	always_ff @(posedge clk) begin
		if (adv[8]) begin
			for (int k = 0; k < tcbct_pkg::N_SQ; k++) begin
				fold_s9[k] <= tcbct_pkg::sq_fold(sqpp_s8[k]);
			end
			ok_s9 <= ok_s8;
		end
	end

	// Stage 10: finish the squares
	always_ff @(posedge clk) begin
		if (adv[9]) begin
			for (int k = 0; k < tcbct_pkg::N_SQ; k++) begin
				sq_s10[k] <= tcbct_pkg::sq_finish(fold_s9[k]);
			end
			ok_s10 <= ok_s9;
		end
	end

	// Stage 11: partial sum of |u|^2
	always_ff @(posedge clk) begin
		if (adv[10]) begin
			uu01_s11 <= sq_s10[0] + sq_s10[1];
			sq2_s11  <= sq_s10[2];
			rr_s11   <= sq_s10[tcbct_pkg::RAD_SLOT];
			ok_s11   <= ok_s10;
		end
	end

	// Stage 12: strict radial compare, output register
	always_ff @(posedge clk) begin
		if (adv[11]) begin
			hit_s12 <= ok_s11 && ((uu01_s11 + sq2_s11) < rr_s11);
		end
	end

	// Input stalls only when every stage holds a transaction
	`TCBCT_ASSERT_NOW(a_stall_only_when_full, !box.ready, &pipe_valid_q, "input stalled with a bubble in the pipe")
	// A zero-length axis never passes the axial check
	`TCBCT_ASSERT_NEXT(a_flat_axis_miss, pipe_valid_q[2] && adv[3] && (d_s3 == '0), !ok_s4, "zero axis passed axial check")
	// A negative scaled radius clears the pass flag
	`TCBCT_ASSERT_NEXT(a_radius_gate, pipe_valid_q[5] && adv[6] && rad_s6[tcbct_pkg::PW-1], !ok_s7, "negative radius kept pass flag")
	// A failed flag can never turn into a hit
	`TCBCT_ASSERT_NEXT(a_flag_gate, pipe_valid_q[10] && adv[11] && !ok_s11, !hit_s12, "hit reported after a failed check")

endmodule
